/* hdl/lzbd_pkg.sv */
// shared types and constants for the lz back-reference stream decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lzbd_pkg;
	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int LANE_BYTES_DEF   = 8;

	localparam logic [7:0]  MAGIC0    = 8'h59;
	localparam logic [7:0]  MAGIC1    = 8'h61;
	localparam logic [7:0]  MAGIC2    = 8'h7A;
	localparam logic [7:0]  MAGIC3    = 8'h30;
	localparam logic [8:0]  LONG_BIAS = 9'h012;
	localparam logic [7:0]  FLAG_MSB  = 8'h80;
	localparam logic [4:0]  HDR_BYTES = 5'h10;
	localparam logic [12:0] DIST_SAT  = 13'd4096;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_MAGIC   = 2'd1;
	localparam logic [1:0] ERR_OVERRUN = 2'd2;
	localparam logic [1:0] ERR_OFFSET  = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_NORMAL = 2'd1,
		PH_SHORT  = 2'd2,
		PH_LONG   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_EMIT = 2'd1,
		KIND_COPY = 2'd2
	} kind_t;

	typedef struct packed {
		logic load;
		logic step;
		logic rd;
		logic wr;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  chunk_done;
		logic  last_byte;
		logic  out_free;
	} sts_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] m;
		case (pos)
			2'd0:    m = MAGIC0;
			2'd1:    m = MAGIC1;
			2'd2:    m = MAGIC2;
			default: m = MAGIC3;
		endcase
		return m;
	endfunction
endpackage
`default_nettype wire

/* hdl/lzbd_in_if.sv */
// input channel: one compressed byte per transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface lzbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

/* hdl/lzbd_out_if.sv */
// output channel: up to eight decoded bytes and status per transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface lzbd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        run_last;
	logic        finished;
	logic [1:0]  error_code;
	modport source (output valid, output out_bytes, output byte_count, output run_last,
		output finished, output error_code, input ready);
	modport sink (input valid, input out_bytes, input byte_count, input run_last,
		input finished, input error_code, output ready);
endinterface
`default_nettype wire

/* hdl/lzbd_ctrl.sv */
// controller state machine: sequences accept, decode and window copy
// depends on lzbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module lzbd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire lzbd_pkg::sts_t sts,
	output lzbd_pkg::cmd_t     cmd
);
	import lzbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECODE = 2'd1,
		ST_CPY_RD = 2'd2,
		ST_CPY_WR = 2'd3
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign in_ready = ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load = in_valid && ready_q;
			ST_DECODE: cmd.step = (sts.kind != KIND_EMIT) || sts.out_free;
			ST_CPY_RD: cmd.rd = 1'b1;
			ST_CPY_WR: cmd.wr = !sts.chunk_done || sts.out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_DECODE;
						ready_q <= 1'b0;
					end
				end
				ST_DECODE: begin
					if (cmd.step) begin
						if (sts.kind == KIND_COPY) begin
							state_q <= ST_CPY_RD;
						end else begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				ST_CPY_RD: state_q <= ST_CPY_WR;
				ST_CPY_WR: begin
					if (cmd.wr) begin
						if (sts.last_byte) begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= ST_CPY_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/lzbd_dp.sv */
// datapath: decode state, history window memory, chunk lane and output register
// depends on lzbd_pkg
`timescale 1ns / 1ps
`default_nettype none
module lzbd_dp #(
	parameter int WINDOW_DEPTH = lzbd_pkg::WINDOW_DEPTH_DEF,
	parameter int LANE_BYTES   = lzbd_pkg::LANE_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata,
	input  wire logic [7:0]     in_byte,
	input  wire lzbd_pkg::cmd_t cmd,
	output lzbd_pkg::sts_t      sts,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [63:0]         out_bytes,
	output logic [3:0]          byte_count,
	output logic                run_last,
	output logic                finished,
	output logic [1:0]          error_code
);
	import lzbd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int PW = (AW > 13) ? AW : 13;
	localparam logic [3:0] LANES = 4'(LANE_BYTES);

	logic [7:0]  mem [WINDOW_DEPTH];
	logic [7:0]  rd_q;
	logic [31:0] forced_q;
	logic [7:0]  byte_q;
	phase_t      phase_q;
	logic [4:0]  hl_q;
	logic [31:0] rem_q;
	logic [7:0]  fb_q;
	logic [7:0]  fs_q;
	logic [7:0]  ph_q;
	logic [12:0] dist_q;
	logic [AW-1:0] ptr_q;
	logic [12:0] prod_q;
	logic [1:0]  err_q;
	logic [8:0]  left_q;
	logic [3:0]  k_q;
	logic [63:0] lane_q;

	kind_t       kind;
	phase_t      nx_phase;
	logic [4:0]  nx_hl;
	logic [31:0] nx_rem;
	logic [7:0]  nx_fb;
	logic [7:0]  nx_fs;
	logic [7:0]  nx_ph;
	logic [12:0] nx_dist;
	logic [1:0]  nx_err;
	logic [8:0]  copy_n;
	logic        lit_wr;
	logic [63:0] e_bytes;
	logic [3:0]  e_count;
	logic        e_fin;
	logic [1:0]  e_err;
	logic [4:0]  hl_n;
	logic [4:0]  pos;
	logic [31:0] rem_hdr;
	logic [31:0] rem_m1;
	logic [12:0] dist_use;
	logic        want_copy;
	logic [AW-1:0] src;
	logic [63:0] lane_new;
	logic        emit_step;
	logic        emit_chunk;
	logic        out_free;

	assign hl_n    = hl_q - 5'd1;
	assign pos     = 5'd15 - hl_n;
	assign rem_m1  = rem_q - 32'd1;
	assign rem_hdr = (pos[4:2] == 3'd1) ? (rem_q | (32'(byte_q) << {~pos[1:0], 3'b000}))
		: rem_q;

	always_comb begin
		kind      = KIND_NONE;
		nx_phase  = phase_q;
		nx_hl     = hl_q;
		nx_rem    = rem_q;
		nx_fb     = fb_q;
		nx_fs     = fs_q;
		nx_ph     = ph_q;
		nx_dist   = dist_q;
		nx_err    = err_q;
		copy_n    = '0;
		lit_wr    = 1'b0;
		e_bytes   = '0;
		e_count   = '0;
		e_fin     = 1'b0;
		e_err     = ERR_NONE;
		dist_use  = dist_q;
		want_copy = 1'b0;
		if (err_q != ERR_NONE) begin
			kind  = KIND_EMIT;
			e_err = err_q;
		end else if (phase_q == PH_HEADER) begin
			nx_hl = hl_n;
			if (pos[4:2] == 3'd0 && byte_q != magic_byte(pos[1:0])) begin
				kind   = KIND_EMIT;
				nx_err = ERR_MAGIC;
				e_err  = ERR_MAGIC;
			end else begin
				nx_rem = rem_hdr;
				if (hl_n == 5'd0) begin
					if (forced_q != 32'd0 && rem_hdr > forced_q) nx_rem = forced_q;
					nx_phase = PH_NORMAL;
					if (nx_rem == 32'd0) begin
						kind  = KIND_EMIT;
						e_fin = 1'b1;
					end
				end
			end
		end else if (rem_q == 32'd0) begin
			kind = KIND_NONE;
		end else if (phase_q == PH_LONG) begin
			copy_n    = 9'(byte_q) + LONG_BIAS;
			want_copy = 1'b1;
		end else if (phase_q == PH_SHORT) begin
			dist_use = {1'b0, ph_q[3:0], byte_q} + 13'd1;
			nx_dist  = dist_use;
			if (ph_q[7:4] != 4'd0) begin
				copy_n    = 9'(ph_q[7:4]) + 9'd2;
				want_copy = 1'b1;
			end else begin
				nx_phase = PH_LONG;
			end
		end else if (fs_q == 8'd0) begin
			nx_fb = byte_q;
			nx_fs = FLAG_MSB;
		end else if ((fb_q & fs_q) == 8'd0) begin
			nx_ph    = byte_q;
			nx_phase = PH_SHORT;
			nx_fs    = fs_q >> 1;
		end else begin
			nx_fs   = fs_q >> 1;
			nx_rem  = rem_m1;
			lit_wr  = 1'b1;
			kind    = KIND_EMIT;
			e_bytes = 64'(byte_q);
			e_count = 4'd1;
			e_fin   = (rem_m1 == 32'd0);
		end
		if (want_copy) begin
			nx_phase = PH_NORMAL;
			if (32'(copy_n) > rem_q) begin
				kind   = KIND_EMIT;
				nx_err = ERR_OVERRUN;
				e_err  = ERR_OVERRUN;
			end else if (dist_use > prod_q) begin
				kind   = KIND_EMIT;
				nx_err = ERR_OFFSET;
				e_err  = ERR_OFFSET;
			end else begin
				kind = KIND_COPY;
			end
		end
	end

	assign src = AW'(PW'(ptr_q) - PW'(dist_q));

	always_comb begin
		lane_new = lane_q;
		lane_new[k_q[2:0]*8 +: 8] = rd_q;
	end

	assign out_free       = !out_valid || out_ready;
	assign sts.kind       = kind;
	assign sts.chunk_done = (k_q + 4'd1 == LANES) || (left_q == 9'd1);
	assign sts.last_byte  = (left_q == 9'd1);
	assign sts.out_free   = out_free;

	assign emit_step  = cmd.step && kind == KIND_EMIT;
	assign emit_chunk = cmd.wr && sts.chunk_done;

	always_ff @(posedge clk) begin
		if (cmd.step && lit_wr) begin
			mem[ptr_q] <= byte_q;
		end else if (cmd.wr) begin
			mem[ptr_q] <= rd_q;
		end
		if (cmd.rd) rd_q <= mem[src];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forced_q  <= '0;
			byte_q    <= '0;
			phase_q   <= PH_HEADER;
			hl_q      <= HDR_BYTES;
			rem_q     <= '0;
			fb_q      <= '0;
			fs_q      <= '0;
			ph_q      <= '0;
			dist_q    <= '0;
			ptr_q     <= '0;
			prod_q    <= '0;
			err_q     <= ERR_NONE;
			left_q    <= '0;
			k_q       <= '0;
			lane_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) forced_q <= cfg_wdata;
			if (cmd.load) byte_q <= in_byte;
			if (cmd.step) begin
				phase_q <= nx_phase;
				hl_q    <= nx_hl;
				rem_q   <= nx_rem;
				fb_q    <= nx_fb;
				fs_q    <= nx_fs;
				ph_q    <= nx_ph;
				dist_q  <= nx_dist;
				err_q   <= nx_err;
				if (lit_wr) begin
					ptr_q <= ptr_q + AW'(1);
					if (prod_q < DIST_SAT) prod_q <= prod_q + 13'd1;
				end
				if (kind == KIND_COPY) begin
					left_q <= copy_n;
					k_q    <= '0;
					lane_q <= '0;
				end
			end
			if (cmd.wr) begin
				ptr_q  <= ptr_q + AW'(1);
				if (prod_q < DIST_SAT) prod_q <= prod_q + 13'd1;
				rem_q  <= rem_m1;
				left_q <= left_q - 9'd1;
				if (sts.chunk_done) begin
					k_q    <= '0;
					lane_q <= '0;
				end else begin
					k_q    <= k_q + 4'd1;
					lane_q <= lane_new;
				end
			end
			if (emit_step || emit_chunk) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_bytes  <= e_bytes;
			byte_count <= e_count;
			run_last   <= 1'b1;
			finished   <= e_fin;
			error_code <= e_err;
		end else if (emit_chunk) begin
			out_bytes  <= lane_new;
			byte_count <= k_q + 4'd1;
			run_last   <= sts.last_byte;
			finished   <= sts.last_byte && (rem_m1 == 32'd0);
			error_code <= ERR_NONE;
		end
	end
endmodule
`default_nettype wire

/* hdl/lz_backref_stream_decoder.sv */
// top level of the lz back-reference stream decoder
// depends on lzbd_pkg, lzbd_in_if, lzbd_out_if, lzbd_ctrl, lzbd_dp
`timescale 1ns / 1ps
`default_nettype none
// Decodes a 16-byte-header LZ77 stream one compressed byte per input transaction.
// Each byte is registered in the idle state and decoded in the decode state; a new byte
// is not taken until the last one, and any copy it starts, is done. A back-reference copy
// runs through the single-port history window: each byte is one registered read followed
// by one write, which keeps overlapping copies exact. A chunk of up to LANE_BYTES bytes
// goes out in one transaction; a full output register stalls the decode and the copy.
// The history memory needs no clearing after reset.
module lz_backref_stream_decoder #(
	parameter int WINDOW_DEPTH = lzbd_pkg::WINDOW_DEPTH_DEF,
	parameter int LANE_BYTES   = lzbd_pkg::LANE_BYTES_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	lzbd_in_if.sink     in_ch,
	lzbd_out_if.source  out_ch,
	input wire logic        cfg_we,
	input wire logic [31:0] cfg_wdata
);
	import lzbd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lzbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzbd_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.LANE_BYTES   (LANE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (in_ch.in_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_bytes  (out_ch.out_bytes),
		.byte_count (out_ch.byte_count),
		.run_last   (out_ch.run_last),
		.finished   (out_ch.finished),
		.error_code (out_ch.error_code)
	);
endmodule
`default_nettype wire

/* hdl/lzbd_checker.sv */
// port-level assertions for the decoder and the bind that attaches them
// depends on lz_backref_stream_decoder
`timescale 1ns / 1ps
`default_nettype none
module lzbd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] byte_count,
	input wire logic       run_last,
	input wire logic       finished,
	input wire logic [1:0] error_code
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count <= 4'd8)
		else $error("byte count above lane width");

	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 2'd0 |-> byte_count == 4'd0 && !finished && run_last)
		else $error("error result carries data");

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> run_last)
		else $error("finished without run end");
endmodule

bind lz_backref_stream_decoder lzbd_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.byte_count (out_ch.byte_count),
	.run_last   (out_ch.run_last),
	.finished   (out_ch.finished),
	.error_code (out_ch.error_code)
);
`default_nettype wire
